// ===== rtl/rvdec_pkg.sv =====
package rvdec_pkg;

   localparam logic [6:0] OPC_LOAD    = 7'h03;
   localparam logic [6:0] OPC_LOADFP  = 7'h07;
   localparam logic [6:0] OPC_MISCMEM = 7'h0f;
   localparam logic [6:0] OPC_OPIMM   = 7'h13;
   localparam logic [6:0] OPC_AUIPC   = 7'h17;
   localparam logic [6:0] OPC_OPIMM32 = 7'h1b;
   localparam logic [6:0] OPC_STORE   = 7'h23;
   localparam logic [6:0] OPC_STOREFP = 7'h27;
   localparam logic [6:0] OPC_AMO     = 7'h2f;
   localparam logic [6:0] OPC_OP      = 7'h33;
   localparam logic [6:0] OPC_LUI     = 7'h37;
   localparam logic [6:0] OPC_OP32    = 7'h3b;
   localparam logic [6:0] OPC_MADD    = 7'h43;
   localparam logic [6:0] OPC_MSUB    = 7'h47;
   localparam logic [6:0] OPC_NMSUB   = 7'h4b;
   localparam logic [6:0] OPC_NMADD   = 7'h4f;
   localparam logic [6:0] OPC_OPFP    = 7'h53;
   localparam logic [6:0] OPC_BRANCH  = 7'h63;
   localparam logic [6:0] OPC_JALR    = 7'h67;
   localparam logic [6:0] OPC_JAL     = 7'h6f;
   localparam logic [6:0] OPC_SYSTEM  = 7'h73;

   localparam logic [14:0] F_RDINT  = 15'h0001;
   localparam logic [14:0] F_RDFP   = 15'h0002;
   localparam logic [14:0] F_S1INT  = 15'h0004;
   localparam logic [14:0] F_S1FP   = 15'h0008;
   localparam logic [14:0] F_S2INT  = 15'h0010;
   localparam logic [14:0] F_S2FP   = 15'h0020;
   localparam logic [14:0] F_S3FP   = 15'h0040;
   localparam logic [14:0] F_UNIQUE = 15'h0080;
   localparam logic [14:0] F_FENCE  = 15'h0100;
   localparam logic [14:0] F_TSO    = 15'h0200;
   localparam logic [14:0] F_PAUSE  = 15'h0400;
   localparam logic [14:0] F_FENCEI = 15'h0800;
   localparam logic [14:0] F_ECALL  = 15'h1000;
   localparam logic [14:0] F_EBREAK = 15'h2000;
   localparam logic [14:0] F_RVC    = 15'h4000;

   localparam logic [31:0] WORD_TSO    = 32'h8330000f;
   localparam logic [31:0] WORD_PAUSE  = 32'h0100000f;
   localparam logic [31:0] WORD_ECALL  = 32'h00000073;
   localparam logic [31:0] WORD_EBREAK = 32'h00100073;

   typedef struct packed {
      logic [6:0]  opc;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm;
      logic [14:0] flags;
      logic        bad;
   } dec_type;

endpackage

// ===== rtl/rvdec_logic.sv =====
module rvdec_logic
   import rvdec_pkg::*;
(
   input  logic [31:0] word,
   output dec_type     dec
);

   dec_type d32;
   dec_type d16;

   // Full-width decode.
   always_comb begin
      logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
      logic [4:0]  fp;
      imm_i = {{20{word[31]}}, word[31:20]};
      imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
      imm_b = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      imm_u = {word[31:12], 12'h000};
      imm_j = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      fp = word[31:27];
      d32 = '0;
      d32.opc = word[6:0];
      d32.rd = word[11:7];
      d32.rs1 = word[19:15];
      d32.rs2 = word[24:20];
      d32.f3 = word[14:12];
      d32.f7 = word[31:25];
      case (word[6:0])
         OPC_LUI, OPC_AUIPC: begin
            d32.imm = imm_u; d32.flags = F_RDINT;
         end
         OPC_JAL: begin
            d32.imm = imm_j; d32.flags = F_RDINT;
         end
         OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_OPIMM32: begin
            d32.imm = imm_i; d32.flags = F_RDINT | F_S1INT;
         end
         OPC_LOADFP: begin
            d32.imm = imm_i; d32.flags = F_RDFP | F_S1INT;
         end
         OPC_BRANCH: begin
            d32.imm = imm_b; d32.flags = F_S1INT | F_S2INT;
         end
         OPC_STORE: begin
            d32.imm = imm_s; d32.flags = F_S1INT | F_S2INT;
         end
         OPC_STOREFP: begin
            d32.imm = imm_s; d32.flags = F_S1INT | F_S2FP;
         end
         OPC_OP, OPC_OP32, OPC_AMO: d32.flags = F_RDINT | F_S1INT | F_S2INT;
         OPC_OPFP: begin
            d32.flags = ((fp == 5'h14 || fp == 5'h18 || fp == 5'h1c) ? F_RDINT : F_RDFP)
                      | ((fp == 5'h1a || fp == 5'h1e) ? F_S1INT : F_S1FP)
                      | ((fp <= 5'h05 || fp == 5'h14) ? F_S2FP : 15'h0000);
         end
         OPC_MADD, OPC_MSUB, OPC_NMADD, OPC_NMSUB:
            d32.flags = F_RDFP | F_S1FP | F_S2FP | F_S3FP;
         OPC_MISCMEM: begin
            d32.imm = imm_i;
            if (word[14:12] == 3'd0) begin
               if (word == WORD_TSO) d32.flags = F_UNIQUE | F_TSO;
               else if (word == WORD_PAUSE) d32.flags = F_UNIQUE | F_PAUSE;
               else d32.flags = F_UNIQUE | F_FENCE;
            end else if (word[14:12] == 3'd1) begin
               d32.flags = F_UNIQUE | F_FENCEI;
            end else begin
               d32.flags = F_UNIQUE | F_RDINT | F_S1INT;
            end
         end
         OPC_SYSTEM: begin
            d32.imm = imm_i;
            if (word == WORD_ECALL) d32.flags = F_UNIQUE | F_ECALL;
            else if (word == WORD_EBREAK) d32.flags = F_UNIQUE | F_EBREAK;
            else begin
               d32.bad = (word[13:12] == 2'b00);
               d32.flags = word[14] ? (F_UNIQUE | F_RDINT)
                                    : (F_UNIQUE | F_RDINT | F_S1INT);
            end
         end
         default: d32.bad = 1'b1;
      endcase
   end

   // Compressed expansion.
   always_comb begin
      logic [2:0]  fn;
      logic        b12;
      logic [4:0]  r5, r5b, rp, rpb;
      logic [31:0] ci, sh, ld, lw, bimm, ldsp, sdsp, a4, a16, lui, jimm, lwsp, swsp;
      logic [2:0]  f3s;
      fn = word[15:13];
      b12 = word[12];
      r5 = word[11:7];
      r5b = word[6:2];
      rp = {2'b01, word[9:7]};
      rpb = {2'b01, word[4:2]};
      ci = {{27{b12}}, r5b};
      sh = {26'd0, b12, r5b};
      ld = {24'd0, word[6:5], word[12:10], 3'd0};
      lw = {25'd0, word[5], word[12:10], word[6], 2'd0};
      bimm = {{24{b12}}, word[6:5], word[2], word[11:10], word[4:3], 1'b0};
      ldsp = {23'd0, word[4:2], b12, word[6:5], 3'd0};
      sdsp = {23'd0, word[9:7], word[12:10], 3'd0};
      a4 = {22'd0, word[10:7], word[12:11], word[5], word[6], 2'd0};
      a16 = {{23{b12}}, word[4:3], word[5], word[2], word[6], 4'd0};
      lui = {{15{b12}}, r5b, 12'd0};
      jimm = {{21{b12}}, word[8], word[10:9], word[6], word[7], word[2], word[11],
              word[5:3], 1'b0};
      lwsp = {24'd0, word[3:2], b12, word[6:4], 2'd0};
      swsp = {24'd0, word[8:7], word[12:9], 2'd0};
      case (word[6:5])
         2'd0: f3s = 3'd0;
         2'd1: f3s = 3'd4;
         2'd2: f3s = 3'd6;
         default: f3s = 3'd7;
      endcase
      d16 = '0;
      d16.flags = F_RVC;
      case (word[1:0])
         2'd0: begin
            case (fn)
               3'd0: begin
                  d16.opc = OPC_OPIMM; d16.rd = rpb; d16.rs1 = 5'd2; d16.imm = a4;
                  d16.flags = F_RVC | F_RDINT | F_S1INT;
               end
               3'd1: begin
                  d16.opc = OPC_LOADFP; d16.rd = rpb; d16.rs1 = rp; d16.f3 = 3'd3;
                  d16.imm = ld; d16.flags = F_RVC | F_RDFP | F_S1INT;
               end
               3'd2, 3'd3: begin
                  d16.opc = OPC_LOAD; d16.rd = rpb; d16.rs1 = rp;
                  d16.f3 = fn[0] ? 3'd3 : 3'd2; d16.imm = fn[0] ? ld : lw;
                  d16.flags = F_RVC | F_RDINT | F_S1INT;
               end
               3'd5: begin
                  d16.opc = OPC_STOREFP; d16.rs1 = rp; d16.rs2 = rpb; d16.f3 = 3'd3;
                  d16.imm = ld; d16.flags = F_RVC | F_S1INT | F_S2FP;
               end
               3'd6, 3'd7: begin
                  d16.opc = OPC_STORE; d16.rs1 = rp; d16.rs2 = rpb;
                  d16.f3 = fn[0] ? 3'd3 : 3'd2; d16.imm = fn[0] ? ld : lw;
                  d16.flags = F_RVC | F_S1INT | F_S2INT;
               end
               default: d16.bad = 1'b1;
            endcase
         end
         2'd1: begin
            case (fn)
               3'd0, 3'd1: begin
                  d16.opc = fn[0] ? OPC_OPIMM32 : OPC_OPIMM; d16.rd = r5; d16.rs1 = r5;
                  d16.imm = ci; d16.flags = F_RVC | F_RDINT | F_S1INT;
               end
               3'd2: begin
                  if (r5 != 5'd0) begin
                     d16.opc = OPC_LUI; d16.rd = r5; d16.imm = ci;
                     d16.flags = F_RVC | F_RDINT;
                  end else d16.bad = 1'b1;
               end
               3'd3: begin
                  if (r5 == 5'd2) begin
                     d16.opc = OPC_OPIMM; d16.rd = 5'd2; d16.rs1 = 5'd2; d16.imm = a16;
                     d16.flags = F_RVC | F_RDINT | F_S1INT;
                  end else if (r5 != 5'd0) begin
                     d16.opc = OPC_LUI; d16.rd = r5; d16.imm = lui;
                     d16.flags = F_RVC | F_RDINT;
                  end else d16.bad = 1'b1;
               end
               3'd4: begin
                  d16.opc = OPC_OPIMM; d16.rd = rp; d16.rs1 = rp;
                  d16.flags = F_RVC | F_RDINT | F_S1INT;
                  case (word[11:10])
                     2'd0: begin d16.f3 = 3'd5; d16.imm = sh; end
                     2'd1: begin d16.f3 = 3'd5; d16.f7 = 7'h20; d16.imm = sh; end
                     2'd2: begin d16.f3 = 3'd7; d16.imm = ci; end
                     default: begin
                        d16.rs2 = rpb;
                        d16.flags = F_RVC | F_RDINT | F_S1INT | F_S2INT;
                        if (b12) begin
                           // Word forms; funct2 of 2 or 3 is reserved but keeps fields.
                           d16.opc = OPC_OP32;
                           d16.f7 = (word[6:5] == 2'd0) ? 7'h20 : 7'h00;
                           d16.bad = word[6];
                        end else begin
                           d16.opc = OPC_OP; d16.f3 = f3s;
                           d16.f7 = (word[6:5] == 2'd0) ? 7'h20 : 7'h00;
                        end
                     end
                  endcase
               end
               3'd5: begin
                  d16.opc = OPC_JAL; d16.imm = jimm; d16.flags = F_RVC | F_RDINT;
               end
               default: begin
                  d16.opc = OPC_BRANCH; d16.rs1 = rp; d16.f3 = {2'd0, fn[0]};
                  d16.imm = bimm; d16.flags = F_RVC | F_S1INT | F_S2INT;
               end
            endcase
         end
         default: begin
            case (fn)
               3'd0: begin
                  if (r5 != 5'd0) begin
                     d16.opc = OPC_OPIMM; d16.rd = r5; d16.rs1 = r5; d16.f3 = 3'd1;
                     d16.imm = sh; d16.flags = F_RVC | F_RDINT | F_S1INT;
                  end else d16.bad = 1'b1;
               end
               3'd1: begin
                  d16.opc = OPC_LOADFP; d16.rd = r5; d16.rs1 = 5'd2; d16.f3 = 3'd3;
                  d16.imm = ldsp; d16.flags = F_RVC | F_RDFP | F_S1INT;
               end
               3'd2, 3'd3: begin
                  d16.opc = OPC_LOAD; d16.rd = r5; d16.rs1 = 5'd2;
                  d16.f3 = fn[0] ? 3'd3 : 3'd2; d16.imm = fn[0] ? ldsp : lwsp;
                  d16.flags = F_RVC | F_RDINT | F_S1INT;
               end
               3'd4: begin
                  if (!b12) begin
                     d16.flags = F_RVC | F_RDINT | F_S1INT;
                     if (r5b != 5'd0) begin
                        d16.opc = OPC_OPIMM; d16.rd = r5; d16.rs1 = r5b;
                     end else begin
                        d16.opc = OPC_JALR; d16.rs1 = r5;
                     end
                  end else if (r5b != 5'd0) begin
                     d16.opc = OPC_OP; d16.rd = r5; d16.rs1 = r5; d16.rs2 = r5b;
                     d16.flags = F_RVC | F_RDINT | F_S1INT | F_S2INT;
                  end else if (r5 != 5'd0) begin
                     d16.opc = OPC_JALR; d16.rd = 5'd1; d16.rs1 = r5;
                     d16.flags = F_RVC | F_RDINT | F_S1INT;
                  end else begin
                     d16.opc = OPC_SYSTEM; d16.imm = 32'd1;
                     d16.flags = F_RVC | F_EBREAK | F_UNIQUE;
                  end
               end
               3'd5: begin
                  d16.opc = OPC_STOREFP; d16.rs1 = 5'd2; d16.rs2 = r5b; d16.f3 = 3'd3;
                  d16.imm = sdsp; d16.flags = F_RVC | F_S1INT | F_S2FP;
               end
               default: begin
                  d16.opc = OPC_STORE; d16.rs1 = 5'd2; d16.rs2 = r5b;
                  d16.f3 = fn[0] ? 3'd3 : 3'd2; d16.imm = fn[0] ? sdsp : swsp;
                  d16.flags = F_RVC | F_S1INT | F_S2INT;
               end
            endcase
         end
      endcase
   end

   assign dec = (word[1:0] == 2'b11) ? d32 : d16;

endmodule

// ===== rtl/rv64gc_instruction_decoder_core.sv =====
// The result of an accepted item is registered and appears on the rsp_ side in the next cycle.
// Throughput: one item per cycle; the decode is a single combinational pass
// into the result register, which accepts a new item whenever it is empty
// or its item is being taken in the same cycle.
// Reset: synchronous, active high; it empties the result register.
module rv64gc_instruction_decoder_core
   import rvdec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] raw_instruction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // opcode, rd, rs1, rs2, f3, f7, imm, flags, illegal
);

   dec_type dec;
   dec_type res_ff;
   logic    valid_ff;
   logic    valid_in;

   rvdec_logic u_logic (.word(req_tdata), .dec(dec));

   assign req_tready = !valid_ff || rsp_tready;
   assign valid_in = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         res_ff <= dec;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {res_ff.bad, res_ff.flags, res_ff.imm, res_ff.f7, res_ff.f3,
                       res_ff.rs2, res_ff.rs1, res_ff.rd, res_ff.opc};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_rvc: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[1:0] != 2'b11 |=> rsp_tdata[78])
      else $error("compressed flag missing");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("stalled while empty");

endmodule

// ===== verif/tb_rv64gc_instruction_decoder_core.sv =====
module tb_rv64gc_instruction_decoder_core
   import rvdec_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   rv64gc_instruction_decoder_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   logic [31:0] word_queue[$];
   dec_type     decode_queue[$];
   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          stim_done = 1'b0;

   function automatic logic [31:0] sx(logic [31:0] v, logic s, logic [31:0] ext);
      return s ? (v | ext) : v;
   endfunction

   function automatic dec_type decode_word32(logic [31:0] w);
      dec_type d;
      logic [4:0] fp;
      d = '0;
      d.opc = w[6:0];
      d.rd = w[11:7];
      d.rs1 = w[19:15];
      d.rs2 = w[24:20];
      d.f3 = w[14:12];
      d.f7 = w[31:25];
      fp = w[31:27];
      case (d.opc)
         OPC_LUI, OPC_AUIPC: begin
            d.imm = {w[31:12], 12'h0}; d.flags = F_RDINT;
         end
         OPC_JAL: begin
            d.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0}; d.flags = F_RDINT;
         end
         OPC_JALR, OPC_LOAD, OPC_OPIMM, OPC_OPIMM32: begin
            d.imm = {{20{w[31]}}, w[31:20]}; d.flags = F_RDINT | F_S1INT;
         end
         OPC_LOADFP: begin
            d.imm = {{20{w[31]}}, w[31:20]}; d.flags = F_RDFP | F_S1INT;
         end
         OPC_BRANCH: begin
            d.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
            d.flags = F_S1INT | F_S2INT;
         end
         OPC_STORE: begin
            d.imm = {{20{w[31]}}, w[31:25], w[11:7]}; d.flags = F_S1INT | F_S2INT;
         end
         OPC_STOREFP: begin
            d.imm = {{20{w[31]}}, w[31:25], w[11:7]}; d.flags = F_S1INT | F_S2FP;
         end
         OPC_OP, OPC_OP32, OPC_AMO: d.flags = F_RDINT | F_S1INT | F_S2INT;
         OPC_OPFP: begin
            d.flags |= (fp == 5'h14 || fp == 5'h18 || fp == 5'h1c) ? F_RDINT : F_RDFP;
            d.flags |= (fp == 5'h1a || fp == 5'h1e) ? F_S1INT : F_S1FP;
            if (fp <= 5'h05 || fp == 5'h14) d.flags |= F_S2FP;
         end
         OPC_MADD, OPC_MSUB, OPC_NMADD, OPC_NMSUB:
            d.flags = F_RDFP | F_S1FP | F_S2FP | F_S3FP;
         OPC_MISCMEM: begin
            d.imm = {{20{w[31]}}, w[31:20]};
            d.flags = F_UNIQUE;
            if (d.f3 == 3'd0) begin
               if (w == WORD_TSO) d.flags |= F_TSO;
               else if (w == WORD_PAUSE) d.flags |= F_PAUSE;
               else d.flags |= F_FENCE;
            end else if (d.f3 == 3'd1) begin
               d.flags |= F_FENCEI;
            end else begin
               d.flags |= F_RDINT | F_S1INT;
            end
         end
         OPC_SYSTEM: begin
            d.imm = {{20{w[31]}}, w[31:20]};
            d.flags = F_UNIQUE;
            if (w == WORD_ECALL) d.flags |= F_ECALL;
            else if (w == WORD_EBREAK) d.flags |= F_EBREAK;
            else begin
               if (d.f3[1:0] == 2'b00) d.bad = 1'b1;
               d.flags |= d.f3[2] ? F_RDINT : (F_RDINT | F_S1INT);
            end
         end
         default: d.bad = 1'b1;
      endcase
      return d;
   endfunction

   function automatic void set_form(inout dec_type d, input logic [6:0] opc,
         input logic [4:0] rd, rs1, rs2, input logic [2:0] f3, input logic [6:0] f7,
         input logic [31:0] imm, input logic [14:0] fl);
      d.opc = opc; d.rd = rd; d.rs1 = rs1; d.rs2 = rs2;
      d.f3 = f3; d.f7 = f7; d.imm = imm; d.flags |= fl;
   endfunction

   function automatic dec_type expand_rvc(logic [15:0] w);
      dec_type d;
      logic [2:0] fn;
      logic b12;
      logic [4:0] r5, r5b, rp, rpb;
      logic [31:0] ci, sh, ld, lw, bimm, ldsp, sdsp, v;
      logic [14:0] ri, rri;
      logic [1:0] f1, f2;
      fn = w[15:13]; b12 = w[12];
      r5 = w[11:7]; r5b = w[6:2];
      rp = {2'b01, w[9:7]}; rpb = {2'b01, w[4:2]};
      ci = sx({27'h0, r5b}, b12, 32'hffffffe0);
      sh = {26'h0, b12, r5b};
      ld = {24'h0, w[6:5], w[12:10], 3'h0};
      lw = {25'h0, w[5], w[12:10], w[6], 2'h0};
      bimm = sx({24'h0, w[6:5], w[2], w[11:10], w[4:3], 1'b0}, b12, 32'hffffff00);
      ldsp = {23'h0, w[4:2], b12, w[6:5], 3'h0};
      sdsp = {23'h0, w[9:7], w[12:10], 3'h0};
      ri = F_RDINT | F_S1INT;
      rri = F_RDINT | F_S1INT | F_S2INT;
      f1 = w[11:10]; f2 = w[6:5];
      d = '0;
      d.flags = F_RVC;
      case (w[1:0])
         2'd0: begin
            case (fn)
               3'd0: begin
                  set_form(d, OPC_OPIMM, rpb, 5'd2, 5'd0, 3'd0, 7'd0,
                     {22'h0, w[10:7], w[12:11], w[5], w[6], 2'h0}, ri);
                  return d;
               end
               3'd1: begin
                  set_form(d, OPC_LOADFP, rpb, rp, 5'd0, 3'd3, 7'd0, ld, F_RDFP | F_S1INT);
                  return d;
               end
               3'd2: begin set_form(d, OPC_LOAD, rpb, rp, 5'd0, 3'd2, 7'd0, lw, ri); return d; end
               3'd3: begin set_form(d, OPC_LOAD, rpb, rp, 5'd0, 3'd3, 7'd0, ld, ri); return d; end
               3'd5: begin
                  set_form(d, OPC_STOREFP, 5'd0, rp, rpb, 3'd3, 7'd0, ld, F_S1INT | F_S2FP);
                  return d;
               end
               3'd6: begin
                  set_form(d, OPC_STORE, 5'd0, rp, rpb, 3'd2, 7'd0, lw, F_S1INT | F_S2INT);
                  return d;
               end
               3'd7: begin
                  set_form(d, OPC_STORE, 5'd0, rp, rpb, 3'd3, 7'd0, ld, F_S1INT | F_S2INT);
                  return d;
               end
               default: ;
            endcase
         end
         2'd1: begin
            if (fn == 3'd0) begin
               set_form(d, OPC_OPIMM, r5, r5, 5'd0, 3'd0, 7'd0, ci, ri); return d;
            end
            if (fn == 3'd1) begin
               set_form(d, OPC_OPIMM32, r5, r5, 5'd0, 3'd0, 7'd0, ci, ri); return d;
            end
            if (fn == 3'd2 && r5 != 0) begin
               set_form(d, OPC_LUI, r5, 5'd0, 5'd0, 3'd0, 7'd0, ci, F_RDINT); return d;
            end
            if (fn == 3'd3 && r5 == 5'd2) begin
               v = {23'h0, w[4:3], w[5], w[2], w[6], 4'h0};
               set_form(d, OPC_OPIMM, 5'd2, 5'd2, 5'd0, 3'd0, 7'd0,
                  sx(v, b12, 32'hfffffe00), ri);
               return d;
            end
            if (fn == 3'd3 && r5 != 0) begin
               set_form(d, OPC_LUI, r5, 5'd0, 5'd0, 3'd0, 7'd0,
                  sx({15'h0, r5b, 12'h0}, b12, 32'hfffe0000), F_RDINT);
               return d;
            end
            if (fn == 3'd4) begin
               if (f1 == 2'd0) begin
                  set_form(d, OPC_OPIMM, rp, rp, 5'd0, 3'd5, 7'd0, sh, ri); return d;
               end
               if (f1 == 2'd1) begin
                  set_form(d, OPC_OPIMM, rp, rp, 5'd0, 3'd5, 7'h20, sh, ri); return d;
               end
               if (f1 == 2'd2) begin
                  set_form(d, OPC_OPIMM, rp, rp, 5'd0, 3'd7, 7'd0, ci, ri); return d;
               end
               if (b12) begin
                  // Reserved funct2 values fall through as illegal but keep OP-32 fields.
                  set_form(d, OPC_OP32, rp, rp, rpb, 3'd0, 7'd0, 32'd0, rri);
                  if (f2 == 2'd0) begin d.f7 = 7'h20; return d; end
                  if (f2 == 2'd1) return d;
               end else begin
                  set_form(d, OPC_OP, rp, rp, rpb,
                     (f2 == 0) ? 3'd0 : (f2 == 1) ? 3'd4 : (f2 == 2) ? 3'd6 : 3'd7,
                     (f2 == 0) ? 7'h20 : 7'h00, 32'd0, rri);
                  return d;
               end
            end
            if (fn == 3'd5) begin
               v = {21'h0, w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
               set_form(d, OPC_JAL, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0,
                  sx(v, b12, 32'hfffff800), F_RDINT);
               return d;
            end
            if (fn == 3'd6 || fn == 3'd7) begin
               set_form(d, OPC_BRANCH, 5'd0, rp, 5'd0, {2'b00, fn[0]}, 7'd0, bimm,
                  F_S1INT | F_S2INT);
               return d;
            end
         end
         default: begin
            case (fn)
               3'd0: if (r5 != 0) begin
                  set_form(d, OPC_OPIMM, r5, r5, 5'd0, 3'd1, 7'd0, sh, ri); return d;
               end
               3'd1: begin
                  set_form(d, OPC_LOADFP, r5, 5'd2, 5'd0, 3'd3, 7'd0, ldsp, F_RDFP | F_S1INT);
                  return d;
               end
               3'd2: begin
                  set_form(d, OPC_LOAD, r5, 5'd2, 5'd0, 3'd2, 7'd0,
                     {24'h0, w[3:2], b12, w[6:4], 2'h0}, ri);
                  return d;
               end
               3'd3: begin set_form(d, OPC_LOAD, r5, 5'd2, 5'd0, 3'd3, 7'd0, ldsp, ri); return d; end
               3'd4: begin
                  if (!b12) begin
                     if (r5b != 0) set_form(d, OPC_OPIMM, r5, r5b, 5'd0, 3'd0, 7'd0, 32'd0, ri);
                     else set_form(d, OPC_JALR, 5'd0, r5, 5'd0, 3'd0, 7'd0, 32'd0, ri);
                  end else if (r5b != 0) begin
                     set_form(d, OPC_OP, r5, r5, r5b, 3'd0, 7'd0, 32'd0, rri);
                  end else if (r5 != 0) begin
                     set_form(d, OPC_JALR, 5'd1, r5, 5'd0, 3'd0, 7'd0, 32'd0, ri);
                  end else begin
                     set_form(d, OPC_SYSTEM, 5'd0, 5'd0, 5'd0, 3'd0, 7'd0, 32'd1,
                        F_EBREAK | F_UNIQUE);
                  end
                  return d;
               end
               3'd5: begin
                  set_form(d, OPC_STOREFP, 5'd0, 5'd2, r5b, 3'd3, 7'd0, sdsp, F_S1INT | F_S2FP);
                  return d;
               end
               3'd6: begin
                  set_form(d, OPC_STORE, 5'd0, 5'd2, r5b, 3'd2, 7'd0,
                     {24'h0, w[8:7], w[12:9], 2'h0}, F_S1INT | F_S2INT);
                  return d;
               end
               default: begin
                  set_form(d, OPC_STORE, 5'd0, 5'd2, r5b, 3'd3, 7'd0, sdsp, F_S1INT | F_S2INT);
                  return d;
               end
            endcase
         end
      endcase
      d.bad = 1'b1;
      return d;
   endfunction

   function automatic dec_type decode_word(logic [31:0] w);
      return (w[1:0] == 2'b11) ? decode_word32(w) : expand_rvc(w[15:0]);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // Driver: holds valid until the item is taken, then offers the next one.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_tdata <= word_queue[0];
               decode_queue.push_back(decode_word(word_queue[0]));
               void'(word_queue.pop_front());
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // Monitor: rsp_tdata carries the opcode in its lowest bits and the illegal flag on top.
   always @(posedge clock) begin
      dec_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.opc = rsp_tdata[6:0];
         got.rd = rsp_tdata[11:7];
         got.rs1 = rsp_tdata[16:12];
         got.rs2 = rsp_tdata[21:17];
         got.f3 = rsp_tdata[24:22];
         got.f7 = rsp_tdata[31:25];
         got.imm = rsp_tdata[63:32];
         got.flags = rsp_tdata[78:64];
         got.bad = rsp_tdata[79];
         if (decode_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_tdata[31:0], 32'h0);
         end else begin
            want = decode_queue.pop_front();
            if (got.opc != want.opc)
               report_mismatch("opcode", 32'(got.opc), 32'(want.opc));
            if (got.rd != want.rd) report_mismatch("rd", 32'(got.rd), 32'(want.rd));
            if (got.rs1 != want.rs1) report_mismatch("rs1", 32'(got.rs1), 32'(want.rs1));
            if (got.rs2 != want.rs2) report_mismatch("rs2", 32'(got.rs2), 32'(want.rs2));
            if (got.f3 != want.f3) report_mismatch("funct3", 32'(got.f3), 32'(want.f3));
            if (got.f7 != want.f7) report_mismatch("funct7", 32'(got.f7), 32'(want.f7));
            if (got.imm != want.imm) report_mismatch("immediate", got.imm, want.imm);
            if (got.flags != want.flags)
               report_mismatch("flags", 32'(got.flags), 32'(want.flags));
            if (got.bad != want.bad)
               report_mismatch("illegal", 32'(got.bad), 32'(want.bad));
         end
      end
   end

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      logic [6:0] opcs[21] = '{OPC_LOAD, OPC_LOADFP, OPC_MISCMEM, OPC_OPIMM, OPC_AUIPC,
         OPC_OPIMM32, OPC_STORE, OPC_STOREFP, OPC_AMO, OPC_OP, OPC_LUI, OPC_OP32, OPC_MADD,
         OPC_MSUB, OPC_NMSUB, OPC_NMADD, OPC_OPFP, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
      w = $urandom();
      case ($urandom_range(9, 0))
         0, 1, 2, 3: w[6:0] = opcs[$urandom_range(20, 0)];
         4, 5, 6, 7: if (w[1:0] == 2'b11) w[1:0] = 2'($urandom_range(2, 0));
         default: ;
      endcase
      return w;
   endfunction

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) word_queue.push_back(random_word());
      while (word_queue.size() > 0 || decode_queue.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] directed[] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0003,
         WORD_TSO, WORD_PAUSE, 32'h0000_000f, 32'h0000_100f, 32'h0000_200f,
         WORD_ECALL, WORD_EBREAK, 32'h1050_0073, 32'h3000_2073, 32'h0000_4073,
         32'hfff0_0063, 32'h8000_006f, 32'hd000_0053, 32'h0000_9002, 32'h0000_8082,
         32'h0000_4081, 32'h0000_6001, 32'h0000_0001, 32'h0000_9c01, 32'h0000_9c41,
         32'h0000_9c61, 32'hffff_0000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) word_queue.push_back(directed[i]);
      run_phase(0, 0, 450);
      run_phase(87, 0, 400);
      run_phase(0, 87, 400);
      run_phase(14, 14, 500);
      repeat (5) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rvdec_pkg.sv
rtl/rvdec_logic.sv
rtl/rv64gc_instruction_decoder_core.sv
verif/tb_rv64gc_instruction_decoder_core.sv
